/* rtl/rtpl_pkg.sv */
// ----------------------------------------------------------------------------
// Route table prefix lookup package
// Shared types and operation codes for the route table lookup block.
// ----------------------------------------------------------------------------
package rtpl_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_BEST    = 2'd1;
    localparam logic [1:0] OP_GATEWAY = 2'd2;

    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [31:0] dst;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [15:0] metric;
        logic [3:0]  intf;
        logic        has_intf;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    typedef struct packed {
        logic load;
        logic rd_en;
        logic out_load;
    } rtpl_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } rtpl_status_t;

endpackage

/* rtl/rtpl_ram.sv */
// ----------------------------------------------------------------------------
// Route table RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rtpl_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rtpl_ctrl.sv */
// ----------------------------------------------------------------------------
// Route table controller
// Sequences item intake, the table scan and the loading of the result.
// ----------------------------------------------------------------------------
module rtpl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            in_op,
    output logic                  in_ready,
    output rtpl_pkg::rtpl_cmd_t    cmd,
    input  rtpl_pkg::rtpl_status_t status
);
    import rtpl_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.load     = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    if ((in_op == OP_BEST) || (in_op == OP_GATEWAY))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded while output register busy");

    a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_BEST || in_op == OP_GATEWAY)) |=> (state_reg == ST_SCAN))
        else $error("lookup item did not start a scan");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && status.scan_last) |=> (state_reg == ST_DRAIN))
        else $error("scan did not end after last slot");

endmodule

/* rtl/rtpl_dp.sv */
// ----------------------------------------------------------------------------
// Route table datapath
// Holds the route table, walks it one slot a cycle and keeps the chosen route.
// ----------------------------------------------------------------------------
module rtpl_dp #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rtpl_pkg::rtpl_cmd_t     cmd,
    output rtpl_pkg::rtpl_status_t  status,
    input  logic [1:0]             in_op,
    input  logic [3:0]             in_index,
    input  rtpl_pkg::route_entry_t  in_entry,
    input  logic                   in_entry_valid,
    input  logic [31:0]            in_query_ip,
    input  logic [3:0]             in_query_intf,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_found,
    output logic [3:0]             out_index,
    output logic [31:0]            out_gateway,
    output logic [3:0]             out_intf,
    output logic [15:0]            out_metric
);
    import rtpl_pkg::*;

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        rd_index_reg;
    logic                     rd_valid_reg;
    logic                     eval_reg;
    logic [1:0]               op_reg;
    logic [31:0]              qip_reg;
    logic [3:0]               qintf_reg;

    logic                     have_reg;
    logic [ADDR_W-1:0]        best_index_reg;
    logic [31:0]              best_mask_reg;
    logic [31:0]              best_gw_reg;
    logic [15:0]              best_metric_reg;
    logic [3:0]               best_intf_reg;

    logic                     out_valid_reg;
    logic                     out_found_reg;
    logic [3:0]               out_index_reg;
    logic [31:0]              out_gateway_reg;
    logic [3:0]               out_intf_reg;
    logic [15:0]              out_metric_reg;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    route_entry_t             rd_entry;
    logic                     best_hit;
    logic                     gw_hit;
    logic                     take;
    logic [7:0]               best_index_ext;

    assign wr_en   = cmd.load && (in_op == OP_WRITE) &&
                     ({28'd0, in_index} < 32'(TABLE_ENTRIES));
    assign wr_addr = ADDR_W'(in_index);

    rtpl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (in_entry),
        .re    (cmd.rd_en),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    assign status.scan_last = (addr_reg == ADDR_W'(TABLE_ENTRIES - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    // A route matches when its masked destination equals the masked query.
    // A longer mask wins, then a lower metric; ties keep the earlier slot.
    assign best_hit = rd_valid_reg &&
                      (((rd_entry.dst ^ qip_reg) & rd_entry.mask) == 32'd0) &&
                      (!have_reg || (rd_entry.mask > best_mask_reg) ||
                       ((rd_entry.mask == best_mask_reg) &&
                        (rd_entry.metric < best_metric_reg)));

    assign gw_hit = rd_valid_reg && rd_entry.has_intf && !have_reg &&
                    (rd_entry.intf == qintf_reg) &&
                    (rd_entry.gateway != 32'd0) &&
                    (rd_entry.gateway != qip_reg);

    assign take = eval_reg &&
                  (((op_reg == OP_BEST) && best_hit) ||
                   ((op_reg == OP_GATEWAY) && gw_hit));

    assign best_index_ext = 8'(best_index_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            eval_reg      <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= in_entry_valid;
            end
            eval_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                have_reg <= 1'b0;
            end
            else if (take)
            begin
                have_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg  <= '0;
            op_reg    <= in_op;
            qip_reg   <= in_query_ip;
            qintf_reg <= in_query_intf;
        end
        else if (cmd.rd_en)
        begin
            addr_reg <= addr_reg + ADDR_W'(1);
        end
        if (cmd.rd_en)
        begin
            rd_index_reg <= addr_reg;
            rd_valid_reg <= valid_reg[addr_reg];
        end
        if (take)
        begin
            best_index_reg  <= rd_index_reg;
            best_mask_reg   <= rd_entry.mask;
            best_gw_reg     <= rd_entry.gateway;
            best_metric_reg <= rd_entry.metric;
            best_intf_reg   <= rd_entry.intf;
        end
        if (cmd.out_load)
        begin
            out_found_reg   <= have_reg;
            out_index_reg   <= have_reg ? best_index_ext[3:0] : 4'd0;
            out_gateway_reg <= have_reg ? best_gw_reg : 32'd0;
            out_intf_reg    <= have_reg ? best_intf_reg : 4'd0;
            out_metric_reg  <= have_reg ? best_metric_reg : 16'd0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_found   = out_found_reg;
    assign out_index   = out_index_reg;
    assign out_gateway = out_gateway_reg;
    assign out_intf    = out_intf_reg;
    assign out_metric  = out_metric_reg;

    a_have_clears_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(have_reg) |-> $past(cmd.load))
        else $error("chosen route dropped outside item start");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

/* rtl/route_table_prefix_lookup_unit.sv */
// ----------------------------------------------------------------------------
// Route table prefix lookup unit
// Sixteen-slot IPv4 route table with write, longest-prefix lookup and
// gateway-by-interface search.
// ----------------------------------------------------------------------------
// A write or unused operation goes from acceptance straight to loading its result once
// the output register is free; a lookup or gateway search first scans every table slot,
// one per cycle through the RAM, then drains the last read. A new item is taken only
// after the result of the last one has been loaded.
// Reset: asynchronous active-low rst_n clears all valid marks and control state.
module route_table_prefix_lookup_unit #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index, entry_dst, entry_mask, entry_gateway, entry_metric, entry_intf,
    // entry_has_intf, entry_valid, query_ip, query_intf, two zero bits.
    input  logic [rtpl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // operation.
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // match_index, match_gateway, match_intf, match_metric.
    output logic [rtpl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // found.
    output logic                            m_axis_tuser
);
    import rtpl_pkg::*;

    rtpl_cmd_t    cmd;
    rtpl_status_t status;
    route_entry_t in_entry;
    logic [3:0]   out_index;
    logic [31:0]  out_gateway;
    logic [3:0]   out_intf;
    logic [15:0]  out_metric;

    assign in_entry.dst      = s_axis_tdata[35:4];
    assign in_entry.mask     = s_axis_tdata[67:36];
    assign in_entry.gateway  = s_axis_tdata[99:68];
    assign in_entry.metric   = s_axis_tdata[115:100];
    assign in_entry.intf     = s_axis_tdata[119:116];
    assign in_entry.has_intf = s_axis_tdata[120];

    rtpl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rtpl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_op          (s_axis_tuser),
        .in_index       (s_axis_tdata[3:0]),
        .in_entry       (in_entry),
        .in_entry_valid (s_axis_tdata[121]),
        .in_query_ip    (s_axis_tdata[153:122]),
        .in_query_intf  (s_axis_tdata[157:154]),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_found      (m_axis_tuser),
        .out_index      (out_index),
        .out_gateway    (out_gateway),
        .out_intf       (out_intf),
        .out_metric     (out_metric)
    );

    assign m_axis_tdata = {out_metric, out_intf, out_gateway, out_index};

endmodule
